### src/tlbl_pkg.sv
`default_nettype none

package tlbl_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 64;
  localparam int SIZE_W     = 13;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
  localparam int MISS_W     = 32;
  localparam int OUT_WAY_W  = 2;

  // One access request
  typedef struct packed {
    logic              tlb_select;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] access_size;
  } request_t;

  // One page lookup result
  typedef struct packed {
    logic [PAGE_NUM_W-1:0] page_number;
    logic                  hit;
    logic [OUT_WAY_W-1:0]  way;
    logic [MISS_W-1:0]     miss_count;
    logic                  last;
  } result_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COMP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write reset row during the clearing pass
    logic accept;  // take the request fields
    logic launch;  // accepted item has lookups to do
    logic read;    // issue the set read
    logic commit;  // write back the set and emit the result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic go;
    logic last_page;
    logic mod_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### src/tlbl_ram.sv
`default_nettype none

module tlbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/tlbl_setmod.sv
`default_nettype none

module tlbl_setmod #(
  parameter int SET_COUNT = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         start,
  input  wire logic [tlbl_pkg::PAGE_NUM_W-1:0]              value,
  output logic                                              busy,
  output logic [(SET_COUNT > 1 ? $clog2(SET_COUNT) : 1)-1:0] rem
);
  import tlbl_pkg::*;

  localparam int SIW      = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;
  localparam bit IS_POW2  = (SET_COUNT & (SET_COUNT - 1)) == 0;
  localparam int DIGIT_W  = 8;
  localparam int STEPS    = (PAGE_NUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int SHW      = STEPS * DIGIT_W;
  localparam int CNT_W    = $clog2(STEPS + 1);

  generate
    if (IS_POW2) begin : g_mask
      // Power of two: set index is the low page bits
      assign busy = 1'b0;
      always_ff @(posedge clk) begin
        if (start) begin
          rem <= value[SIW-1:0] & SIW'(SET_COUNT - 1);
        end
      end
    end else begin : g_div
      logic [SHW-1:0]   shreg;
      logic [CNT_W-1:0] cnt;
      logic [SIW-1:0]   rem_next;
      logic [SIW:0]     trial;

      assign busy = cnt != '0;

      // Eight remainder steps per cycle, most significant digit first
      always_comb begin
        rem_next = rem;
        trial    = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
          trial = {rem_next, shreg[SHW-1-i]};
          if (trial >= (SIW+1)'(SET_COUNT)) begin
            trial = trial - (SIW+1)'(SET_COUNT);
          end
          rem_next = trial[SIW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          cnt <= '0;
        end else if (start) begin
          cnt <= CNT_W'(STEPS);
        end else if (busy) begin
          cnt <= cnt - CNT_W'(1);
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          shreg <= SHW'(value);
          rem   <= '0;
        end else if (busy) begin
          shreg <= shreg << DIGIT_W;
          rem   <= rem_next;
        end
      end
    end
  endgenerate

endmodule

`default_nettype wire

### src/tlbl_datapath.sv
`default_nettype none

module tlbl_datapath #(
  parameter int SET_COUNT        = 16,
  parameter int WAY_COUNT        = 4,
  parameter int MAX_ACCESS_BYTES = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_wr_data,
  input  wire tlbl_pkg::request_t    request,
  input  wire tlbl_pkg::dp_cmd_t     cmd,
  output tlbl_pkg::dp_status_t       status,
  output tlbl_pkg::result_t          result,
  output logic                       result_valid
);
  import tlbl_pkg::*;

  localparam int ROWS     = 2 * SET_COUNT;
  localparam int RAW      = $clog2(ROWS);
  localparam int SIW      = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;
  localparam int AW       = WAY_COUNT > 1 ? $clog2(WAY_COUNT) : 1;
  localparam int TAG_W    = PAGE_NUM_W;
  localparam int AGE_BASE = WAY_COUNT * TAG_W;
  localparam int VLD_BASE = AGE_BASE + WAY_COUNT * AW;
  localparam int ROW_W    = VLD_BASE + WAY_COUNT;
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_ACCESS_BYTES);

  // Item registers
  logic                  tracking;
  logic                  tlb;
  logic [PAGE_NUM_W-1:0] page;
  logic                  two_pages;
  logic                  second;
  logic [RAW-1:0]        clr_row;
  logic [MISS_W-1:0]     miss_cnt [2];

  logic                  mod_busy;
  logic [SIW-1:0]        rem;
  logic [SIW-1:0]        set_cur;
  logic [RAW-1:0]        row;
  logic                  last_page;

  logic [SIZE_W-1:0]     size_sat;
  logic [ADDR_W-1:0]     high_addr;
  logic [ADDR_W-1:0]     next_addr;
  logic                  two_pages_in;

  logic [ROW_W-1:0]      rdata;
  logic [ROW_W-1:0]      wdata;
  logic [ROW_W-1:0]      new_row;
  logic [ROW_W-1:0]      init_row;
  logic [RAW-1:0]        waddr;

  logic [TAG_W-1:0]      tag_q  [WAY_COUNT];
  logic [AW-1:0]         age_q  [WAY_COUNT];
  logic                  vld_q  [WAY_COUNT];
  logic                  hit;
  logic [AW-1:0]         hit_way;
  logic [AW-1:0]         victim;
  logic [AW-1:0]         use_way;
  logic [AW-1:0]         use_rank;
  logic [MISS_W-1:0]     miss_sel;
  logic [MISS_W-1:0]     miss_new;

  // Set index of the first page
  tlbl_setmod #(
    .SET_COUNT (SET_COUNT)
  ) u_setmod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.launch),
    .value (request.address[ADDR_W-1:PAGE_SHIFT]),
    .busy  (mod_busy),
    .rem   (rem)
  );

  // Row store: valid bits, age ranks and tags of one set
  tlbl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.clear | cmd.commit),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.read),
    .raddr (row),
    .rdata (rdata)
  );

  // Page split of the incoming request
  always_comb begin
    size_sat     = (request.access_size > MAX_SIZE) ? MAX_SIZE : request.access_size;
    high_addr    = request.address + ADDR_W'(size_sat);
    next_addr    = {request.address[ADDR_W-1:PAGE_SHIFT] + PAGE_NUM_W'(1), PAGE_SHIFT'(0)};
    two_pages_in = (next_addr < high_addr) && (next_addr >= request.address);
  end

  // Set and row of the current lookup; the second page is the next set
  always_comb begin
    if (second) begin
      set_cur = (rem == SIW'(SET_COUNT - 1)) ? '0 : rem + SIW'(1);
    end else begin
      set_cur = rem;
    end
    row       = tlb ? RAW'(SET_COUNT) + RAW'(set_cur) : RAW'(set_cur);
    last_page = second || !two_pages;
    waddr     = cmd.clear ? clr_row : row;
    wdata     = cmd.clear ? init_row : new_row;
  end

  // Row as written by the clearing pass
  always_comb begin
    init_row = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      init_row[AGE_BASE + w*AW +: AW] = AW'(w);
    end
  end

  // Tag compare, victim choice and rank update
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    victim  = '0;
    new_row = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      tag_q[w] = rdata[w*TAG_W +: TAG_W];
      age_q[w] = rdata[AGE_BASE + w*AW +: AW];
      vld_q[w] = rdata[VLD_BASE + w];
    end
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (vld_q[w] && tag_q[w] == page) begin
        hit     = 1'b1;
        hit_way = AW'(w);
      end
    end
    // ranks form a permutation, so the oldest way holds the top rank
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (age_q[w] == AW'(WAY_COUNT - 1)) begin
        victim = AW'(w);
      end
    end
    use_way  = hit ? hit_way : victim;
    use_rank = age_q[use_way];
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (AW'(w) == use_way) begin
        new_row[w*TAG_W +: TAG_W]        = page;
        new_row[AGE_BASE + w*AW +: AW]   = '0;
        new_row[VLD_BASE + w]            = 1'b1;
      end else begin
        new_row[w*TAG_W +: TAG_W]        = tag_q[w];
        new_row[AGE_BASE + w*AW +: AW]   = (age_q[w] < use_rank) ? age_q[w] + AW'(1)
                                                                 : age_q[w];
        new_row[VLD_BASE + w]            = vld_q[w];
      end
    end
    miss_sel = miss_cnt[tlb];
    miss_new = hit ? miss_sel : miss_sel + MISS_W'(1);
  end

  // Status to the controller
  always_comb begin
    status.clear_last = clr_row == RAW'(ROWS - 1);
    status.go         = tracking && (request.access_size != '0);
    status.last_page  = last_page;
    status.mod_busy   = mod_busy;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking     <= 1'b1;
      clr_row      <= '0;
      miss_cnt[0]  <= '0;
      miss_cnt[1]  <= '0;
      second       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tracking <= cfg_wr_data;
      end
      if (cmd.clear) begin
        clr_row <= clr_row + RAW'(1);
      end
      result_valid <= cmd.commit;
      if (cmd.commit) begin
        miss_cnt[tlb] <= miss_new;
        if (!last_page) begin
          second <= 1'b1;
        end
      end
      if (cmd.accept) begin
        second <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!last_page) begin
        page <= page + PAGE_NUM_W'(1);
      end
      result.page_number <= page;
      result.hit         <= hit;
      result.way         <= OUT_WAY_W'(use_way);
      result.miss_count  <= miss_new;
      result.last        <= last_page;
    end
    if (cmd.accept) begin
      tlb       <= request.tlb_select;
      page      <= request.address[ADDR_W-1:PAGE_SHIFT];
      two_pages <= two_pages_in;
    end
  end

endmodule

`default_nettype wire

### src/tlbl_ctrl.sv
`default_nettype none

module tlbl_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire tlbl_pkg::dp_status_t  status,
  output logic                       busy,
  output tlbl_pkg::dp_cmd_t          cmd
);
  import tlbl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.launch) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (!status.mod_busy) begin
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        if (!status.last_page || cmd.launch) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs; a new item is taken while idle or during the final compare cycle
  always_comb begin
    busy       = !((state == ST_IDLE) || (state == ST_COMP && status.last_page));
    cmd.clear  = state == ST_CLEAR;
    cmd.accept = start && !busy;
    cmd.launch = cmd.accept && status.go;
    cmd.read   = (state == ST_READ) && !status.mod_busy;
    cmd.commit = state == ST_COMP;
  end

endmodule

`default_nettype wire

### src/split_l1_tlb_lru_lookup.sv
// Channel   Signals                          Handshake
// -------   -------------------------------  ------------------------------
// request   start, busy, request             taken when start && !busy
// result    result_valid, result             one cycle per result, no stall
// config    cfg_wr_en, cfg_wr_data           written when cfg_wr_en
//
// Each page lookup is a set read from the row RAM, then a compare and
// write-back. An access with tracking on and nonzero size gives 1 or 2
// results, else none. A registered result shows in the cycle after
// its compare cycle; the next item is taken in the last compare cycle. If
// SET_COUNT is not a power of two, the set index unit stalls set reads.
// After reset a clearing pass over all 2*SET_COUNT rows holds busy high.
`default_nettype none

module split_l1_tlb_lru_lookup #(
  parameter int SET_COUNT        = 16,
  parameter int WAY_COUNT        = 4,
  parameter int MAX_ACCESS_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data,
  input  wire logic                start,
  input  wire tlbl_pkg::request_t  request,
  output logic                     busy,
  output tlbl_pkg::result_t        result,
  output logic                     result_valid
);
  import tlbl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tlbl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  tlbl_datapath #(
    .SET_COUNT        (SET_COUNT),
    .WAY_COUNT        (WAY_COUNT),
    .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .request      (request),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

`default_nettype wire

### src/tlbl_checker.sv
`default_nettype none

module tlbl_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               busy,
  input wire logic               result_valid,
  input wire tlbl_pkg::result_t  result
);
  import tlbl_pkg::*;

  // Clearing pass holds off items right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> busy)
    else $error("busy low right after reset");

  // Second lookup of an access follows the first after its set read
  a_second_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> ##2 (result_valid && result.last))
    else $error("second page result missing");

  // Second lookup is the next page
  a_next_page: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> ##2
      (result.page_number == $past(result.page_number, 2) + PAGE_NUM_W'(1)))
    else $error("second page number wrong");

  // Same TLB: counter moves by one on a miss only
  a_miss_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> ##2
      (result.hit ? (result.miss_count == $past(result.miss_count, 2))
                  : (result.miss_count == $past(result.miss_count, 2) + MISS_W'(1))))
    else $error("miss counter step wrong");

endmodule

bind split_l1_tlb_lru_lookup tlbl_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import tlbl_pkg::*;

  localparam int SETS      = 16;
  localparam int WAYS      = 4;
  localparam int MAX_BYTES = 4096;
  localparam int MAX_PAGES = 2;
  localparam logic [ADDR_W-1:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;
  localparam logic [SIZE_W-1:0] SIZE_CAP   = SIZE_W'(MAX_BYTES);
  localparam int DRAIN_CYCLES = 10;

  // Shadow copy of both TLBs; predicts the page lookups of each accepted item
  class lru_tlb_checker;
    logic [PAGE_NUM_W-1:0] tag [2][SETS][WAYS];
    bit                    valid [2][SETS][WAYS];
    logic [1:0]            age [2][SETS][WAYS];
    logic [MISS_W-1:0]     misses [2];
    bit                    tracking;
    result_t               pending_lookups [$];
    int                    failures;

    function new();
      for (int t = 0; t < 2; t++) begin
        for (int s = 0; s < SETS; s++) begin
          for (int w = 0; w < WAYS; w++) begin
            tag[t][s][w]   = '0;
            valid[t][s][w] = 1'b0;
            age[t][s][w]   = 2'(w);
          end
        end
        misses[t] = '0;
      end
      tracking = 1'b1;
      failures = 0;
    endfunction

    // One page: tag compare, fill of the oldest way on a miss, LRU aging
    function void lookup(int t, logic [PAGE_NUM_W-1:0] pg, output bit hit, output int used);
      int s;
      logic [1:0] oldest;
      logic [1:0] used_age;
      s = int'(pg % SETS);
      hit = 1'b0;
      used = 0;
      for (int w = 0; w < WAYS; w++) begin
        if (!hit && valid[t][s][w] && tag[t][s][w] == pg) begin
          hit = 1'b1;
          used = w;
        end
      end
      if (!hit) begin
        misses[t] = misses[t] + 1'b1;
        oldest = '0;
        for (int w = 0; w < WAYS; w++) begin
          if (age[t][s][w] >= oldest) begin
            oldest = age[t][s][w];
            used = w;
          end
        end
        valid[t][s][used] = 1'b1;
        tag[t][s][used] = pg;
      end
      used_age = age[t][s][used];
      for (int w = 0; w < WAYS; w++) begin
        if (age[t][s][w] < used_age) age[t][s][w] = age[t][s][w] + 1'b1;
      end
      age[t][s][used] = '0;
    endfunction

    // Accepted item: walk the pages it touches, queue one lookup per page
    function void take_access(request_t req);
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] orig;
      logic [ADDR_W-1:0] high;
      logic [ADDR_W-1:0] nxt;
      logic [SIZE_W-1:0] sz;
      result_t r;
      bit hit;
      bit more;
      int used;
      int t;
      if (!tracking || req.access_size == '0) return;
      t = int'(req.tlb_select);
      sz = (req.access_size > SIZE_CAP) ? SIZE_CAP : req.access_size;
      addr = req.address;
      orig = addr;
      high = addr + ADDR_W'(sz);
      for (int n = 0; n < MAX_PAGES; n++) begin
        lookup(t, addr[ADDR_W-1:PAGE_SHIFT], hit, used);
        nxt = {addr[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} + PAGE_BYTES;
        more = (nxt < high) && (nxt >= orig) && (n + 1 < MAX_PAGES);
        r.page_number = addr[ADDR_W-1:PAGE_SHIFT];
        r.hit = hit;
        r.way = OUT_WAY_W'(used);
        r.miss_count = misses[t];
        r.last = !more;
        pending_lookups.push_back(r);
        if (!more) break;
        addr = nxt;
      end
    endfunction

    function void check_lookup(result_t got);
      result_t want;
      if (pending_lookups.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected result page=%h hit=%b way=%0d miss=%0d last=%b",
                   got.page_number, got.hit, got.way, got.miss_count, got.last);
        return;
      end
      want = pending_lookups.pop_front();
      if (got.page_number !== want.page_number || got.hit !== want.hit ||
          got.way !== want.way || got.miss_count !== want.miss_count ||
          got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("ERROR: exp page=%h hit=%b way=%0d miss=%0d last=%b",
                   want.page_number, want.hit, want.way, want.miss_count, want.last);
          $display("       got page=%h hit=%b way=%0d miss=%0d last=%b",
                   got.page_number, got.hit, got.way, got.miss_count, got.last);
        end
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_wr_en = 1'b0;
  logic     cfg_wr_data = 1'b0;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  result_t  result;
  logic     result_valid;

  lru_tlb_checker board = new();

  // Pages reused by the random part so that hits and LRU evictions happen
  logic [PAGE_NUM_W-1:0] page_pool [32];

  split_l1_tlb_lru_lookup u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results cannot be held off: check every strobed one
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) board.check_lookup(result);
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Small sizes most often, some up to a page, some near or above the cap
  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 45) return SIZE_W'($urandom_range(1, 64));
    if (r < 75) return SIZE_W'($urandom_range(1, MAX_BYTES));
    if (r < 88) return SIZE_W'($urandom_range(MAX_BYTES - 1, MAX_BYTES + 1));
    return SIZE_W'($urandom_range(MAX_BYTES + 1, 8191));
  endfunction

  // Pool pages crowd a few sets so ways get evicted often
  function automatic void refill_pool();
    logic [PAGE_NUM_W-1:0] pg;
    for (int i = 0; i < 32; i++) begin
      pg = PAGE_NUM_W'(rand_addr());
      pg[3:0] = 4'($urandom_range(0, 5));
      page_pool[i] = pg;
    end
  endfunction

  function automatic request_t make_request();
    request_t req;
    logic [PAGE_SHIFT-1:0] ofs;
    int k;
    k = $urandom_range(0, 99);
    req.tlb_select = 1'($urandom_range(0, 1));
    req.access_size = rand_size();
    if (k < 65) begin
      // reused page, often starting near its end to cross into the next
      if ($urandom_range(0, 1) == 1) ofs = PAGE_SHIFT'(MAX_BYTES - $urandom_range(1, 64));
      else ofs = PAGE_SHIFT'($urandom);
      req.address = {page_pool[$urandom_range(0, 31)], ofs};
    end else if (k < 82) begin
      req.address = rand_addr();
    end else if (k < 92) begin
      // top of the address space, where the walk wraps
      req.address = ~64'd0 - ADDR_W'($urandom_range(0, 8191));
    end else begin
      req.address = rand_addr();
      req.access_size = '0;
    end
    return req;
  endfunction

  function automatic int pick_gap(bit quiet);
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 14);
  endfunction

  // Called at a clock edge; returns at the edge that took the item
  task automatic send_access(request_t req, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy !== 1'b0);
    board.take_access(req);
  endtask

  // Stop sending, let every lookup come out and the block go idle
  task automatic settle();
    start <= 1'b0;
    while (board.pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_tracking(bit on);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.tracking = on;
  endtask

  task automatic send_one(logic sel, logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] sz);
    request_t req;
    req.tlb_select = sel;
    req.address = addr;
    req.access_size = sz;
    send_access(req, pick_gap(1'b0));
  endtask

  task automatic run_phase(bit on, int count, bit quiet);
    request_t req;
    int done;
    done = 0;
    set_tracking(on);
    refill_pool();
    while (done < count) begin
      req = make_request();
      send_access(req, pick_gap(quiet));
      done++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    set_tracking(1'b1);
    send_one(1'b0, 64'd0, 13'd1);                       // cold miss
    send_one(1'b0, 64'd0, 13'd1);                       // hit
    send_one(1'b1, 64'd0, 13'd1);                       // other TLB still cold
    send_one(1'b0, ~64'd0, 13'd1);                      // top page
    send_one(1'b0, ~64'd0, 13'd8191);                   // capped, end wraps
    send_one(1'b1, 64'hFFFF_FFFF_FFFF_F000, 13'd4096);  // end wraps to zero
    send_one(1'b0, 64'hFFFF_FFFF_FFFF_E800, 13'd4096);  // two pages below the top
    send_one(1'b0, 64'h0000_0000_0000_1FFF, 13'd2);     // crosses a page
    send_one(1'b1, 64'h0000_0000_0000_3000, 13'd4096);  // aligned full page
    send_one(1'b0, 64'h0000_0000_0000_3800, 13'd8191);  // capped, two pages
    send_one(1'b0, rand_addr(), 13'd0);                 // zero size
    // five pages into one set: the fifth evicts the first
    for (int i = 0; i < 5; i++) send_one(1'b0, ADDR_W'(5 + 16 * i) << PAGE_SHIFT, 13'd8);
    send_one(1'b0, 64'd5 << PAGE_SHIFT, 13'd8);         // evicted page misses
    send_one(1'b0, 64'd69 << PAGE_SHIFT, 13'd8);        // recent page hits
    send_one(1'b1, 64'd5 << PAGE_SHIFT, 13'd8);
    send_one(1'b1, 64'h0000_0000_0000_0FFF, 13'd4097);  // capped, two pages

    // Random part over several settings; the last stretch runs back to back
    run_phase(1'b0, 40, 1'b0);
    run_phase(1'b1, 600, 1'b0);
    run_phase(1'b0, 30, 1'b0);
    run_phase(1'b1, 600, 1'b0);
    run_phase(1'b1, 550, 1'b1);

    settle();
    if (board.pending_lookups.size() != 0)
      $display("ERROR: %0d lookups never came out", board.pending_lookups.size());
    if (board.failures == 0 && board.pending_lookups.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/tlbl_pkg.sv
src/tlbl_ram.sv
src/tlbl_setmod.sv
src/tlbl_datapath.sv
src/tlbl_ctrl.sv
src/split_l1_tlb_lru_lookup.sv
src/tlbl_checker.sv
verif/tb.sv
